// ----- hdl/tth_pkg.sv -----
// shared types, constants and bcd decode helpers for the trunk traffic histogram table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tth_pkg;

	localparam int ENTRIES = 256;
	localparam int SLOTS   = 20;
	localparam int PW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW      = $clog2(ENTRIES + 1);
	localparam int CBW     = $clog2(ENTRIES * SLOTS);
	localparam int KAW     = PW + 1;
	localparam int CAW     = CBW + 1;

	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CAT  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NO_ENTRY = 2'd3;

	localparam logic [7:0] HID_CODE0 = 8'haa;
	localparam logic [7:0] HID_CODE1 = 8'hab;

	localparam logic [4:0] LDC_BASE = 5'd2;
	localparam logic [4:0] CCE_BASE = 5'd6;
	localparam logic [4:0] TM_BASE  = 5'd11;
	localparam logic [4:0] SLOT_LAST = 5'(SLOTS - 1);

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  hid_code;
		logic [7:0]  ldc_code;
		logic [7:0]  cce_code;
		logic [7:0]  tm_code;
		logic [15:0] in_trunk_code;
		logic [15:0] out_trunk_code;
		logic        table_select;
		logic [7:0]  read_index;
	} rec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        which_table;
		logic [7:0]  entry_position;
		logic [13:0] trunk_number;
		logic [4:0]  counter_slot;
		logic [31:0] counter_value;
		logic        last;
	} res_t;

	// decode stops at the first nibble above nine
	function automatic logic [6:0] bcd2(input logic [7:0] c);
		logic [6:0] v;
		logic       stop;
		v = '0;
		stop = 1'b0;
		for (int k = 1; k >= 0; k--) begin
			if (c[4*k +: 4] > 4'd9) stop = 1'b1;
			if (!stop) v = 7'(v * 7'd10 + 7'(c[4*k +: 4]));
		end
		return v;
	endfunction

	function automatic logic [13:0] bcd4(input logic [15:0] c);
		logic [13:0] v;
		logic        stop;
		v = '0;
		stop = 1'b0;
		for (int k = 3; k >= 0; k--) begin
			if (c[4*k +: 4] > 4'd9) stop = 1'b1;
			if (!stop) v = 14'(v * 14'd10 + 14'(c[4*k +: 4]));
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/tth_if.sv -----
// valid/ready channel interfaces for records and results
// depends on tth_pkg
`timescale 1ns / 1ps
`default_nettype none
interface tth_rec_if;
	logic          valid;
	logic          ready;
	tth_pkg::rec_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tth_res_if;
	logic          valid;
	logic          ready;
	tth_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/trunk_traffic_histogram_table_core.sv -----
// trunk traffic histogram table: sequencer, key and counter rams
// depends on tth_pkg, tth_if, tth_ram
// count record: per table, a key search over the used entries, then a read-modify-write of the four
//   selected counters on a hit or a sweep over all slots on an append; read: one result per slot
// throughput: one record at a time, bounded by the key search (one key ram read a cycle)
// reset: arst_n clears sequencer state and both fill counts; rams hold no reset
`timescale 1ns / 1ps
`default_nettype none
module trunk_traffic_histogram_table_core (
	input wire logic clk,
	input wire logic arst_n,
	tth_rec_if.sink  rec,
	tth_res_if.source res
);
	import tth_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRCH   = 4'd1;
	localparam logic [3:0] S_APPEND = 4'd2;
	localparam logic [3:0] S_UPD_RD = 4'd3;
	localparam logic [3:0] S_UPD_WR = 4'd4;
	localparam logic [3:0] S_RD_KEY = 4'd5;
	localparam logic [3:0] S_RD_CNT = 4'd6;
	localparam logic [3:0] S_RD_DAT = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;

	logic [3:0]      state_q;
	logic            tbl_q;
	logic [UW-1:0]   idx_q;
	logic            cmp_v_q;
	logic [PW-1:0]   cmp_idx_q;
	logic [PW-1:0]   pos_q;
	logic [4:0]      k_q;
	logic [4:0]      sl_q [4];
	logic [13:0]     itg_q, otg_q;
	logic [13:0]     key_q;
	logic [1:0]      cmd_q;
	logic [UW-1:0]   in_used_q, out_used_q;
	logic            out_v_q;
	res_t            out_q;

	// key ram and counter ram, table select is the top address bit
	logic           key_we;
	logic [KAW-1:0] key_waddr, key_raddr;
	logic [13:0]    key_wdata, key_rdata;
	logic           cnt_we;
	logic [CAW-1:0] cnt_waddr, cnt_raddr;
	logic [31:0]    cnt_wdata, cnt_rdata;

	tth_ram #(.WIDTH(14), .DEPTH(1 << KAW)) u_keys (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	tth_ram #(.WIDTH(32), .DEPTH(1 << CAW)) u_cnts (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	// record decode, taken straight off the channel
	logic [6:0]  ldc_d, cce_d, tm_d;
	logic        bad_cat;
	logic        idx_ok;
	logic [UW-1:0] used_rd;

	assign ldc_d   = bcd2(rec.data.ldc_code);
	assign cce_d   = bcd2(rec.data.cce_code);
	assign tm_d    = bcd2(rec.data.tm_code);
	assign bad_cat = (rec.data.hid_code != HID_CODE0 && rec.data.hid_code != HID_CODE1)
		|| ldc_d > 7'd3 || cce_d > 7'd4 || tm_d > 7'd8;
	assign used_rd = rec.data.table_select ? out_used_q : in_used_q;
	assign idx_ok  = (32'(rec.data.read_index) < 32'(used_rd))
		&& (32'(rec.data.read_index) < 32'(ENTRIES));

	// working values for the table being handled
	logic [UW-1:0]  used_sel;
	logic [13:0]    trunk_sel;
	logic           hit;
	logic [CBW-1:0] base;
	logic           in_sl;

	assign used_sel  = tbl_q ? out_used_q : in_used_q;
	assign trunk_sel = tbl_q ? otg_q : itg_q;
	assign hit       = cmp_v_q && (key_rdata == trunk_sel);
	assign base      = CBW'(pos_q) * CBW'(SLOTS);
	assign in_sl     = (k_q == sl_q[0]) || (k_q == sl_q[1]) || (k_q == sl_q[2])
		|| (k_q == sl_q[3]);

	assign rec.ready = (state_q == S_IDLE);
	assign res.valid = out_v_q;
	assign res.data  = out_q;

	// ram port steering
	always_comb begin
		key_we    = 1'b0;
		key_waddr = {tbl_q, pos_q};
		key_wdata = trunk_sel;
		key_raddr = {tbl_q, PW'(idx_q)};
		cnt_we    = 1'b0;
		cnt_waddr = {tbl_q, CBW'(base + CBW'(k_q))};
		cnt_wdata = in_sl ? 32'd1 : 32'd0;
		cnt_raddr = {tbl_q, CBW'(base + CBW'(k_q))};
		case (state_q)
			S_APPEND: begin
				key_we = (k_q == 5'd0);
				cnt_we = 1'b1;
			end
			S_UPD_RD: cnt_raddr = {tbl_q, CBW'(base + CBW'(sl_q[k_q[1:0]]))};
			S_UPD_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = {tbl_q, CBW'(base + CBW'(sl_q[k_q[1:0]]))};
				cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 32'd1;
			end
			S_RD_KEY: key_raddr = {tbl_q, pos_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_v_q    <= 1'b0;
			in_used_q  <= '0;
			out_used_q <= '0;
			cmp_v_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rec.valid) begin
						cmd_q   <= rec.data.cmd;
						itg_q   <= bcd4(rec.data.in_trunk_code);
						otg_q   <= bcd4(rec.data.out_trunk_code);
						sl_q[0] <= (rec.data.hid_code == HID_CODE1) ? 5'd1 : 5'd0;
						sl_q[1] <= LDC_BASE + 5'(ldc_d);
						sl_q[2] <= CCE_BASE + 5'(cce_d);
						sl_q[3] <= TM_BASE + 5'(tm_d);
						tbl_q   <= 1'b0;
						idx_q   <= '0;
						cmp_v_q <= 1'b0;
						k_q     <= '0;
						out_q   <= '0;
						case (rec.data.cmd)
							CMD_COUNT: begin
								if (bad_cat) begin
									out_q.status <= ST_BAD_CAT;
									out_q.last   <= 1'b1;
									out_v_q      <= 1'b1;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_SRCH;
								end
							end
							CMD_READ: begin
								tbl_q <= rec.data.table_select;
								pos_q <= PW'(rec.data.read_index);
								if (idx_ok) begin
									state_q <= S_RD_KEY;
								end else begin
									out_q.status         <= ST_NO_ENTRY;
									out_q.which_table    <= rec.data.table_select;
									out_q.entry_position <= rec.data.read_index;
									out_q.last           <= 1'b1;
									out_v_q              <= 1'b1;
									state_q              <= S_EMIT;
								end
							end
							CMD_CLEAR: begin
								in_used_q  <= '0;
								out_used_q <= '0;
								out_q.last <= 1'b1;
								out_v_q    <= 1'b1;
								state_q    <= S_EMIT;
							end
							default: ;
						endcase
					end
				end
				// one key read issued per cycle, compared in the following cycle once the ram returns it
				S_SRCH: begin
					if (hit) begin
						cmp_v_q <= 1'b0;
						pos_q   <= cmp_idx_q;
						k_q     <= '0;
						state_q <= S_UPD_RD;
					end else if (idx_q < used_sel) begin
						cmp_v_q   <= 1'b1;
						cmp_idx_q <= PW'(idx_q);
						idx_q     <= idx_q + 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
						if (32'(used_sel) >= 32'(ENTRIES)) begin
							out_q             <= '0;
							out_q.status      <= ST_FULL;
							out_q.which_table <= tbl_q;
							out_q.trunk_number <= trunk_sel;
							out_q.last        <= tbl_q;
							out_v_q           <= 1'b1;
							state_q           <= S_EMIT;
						end else begin
							pos_q   <= PW'(used_sel);
							k_q     <= '0;
							state_q <= S_APPEND;
						end
					end
				end
				// new entry: key plus a sweep over all slots
				S_APPEND: begin
					if (k_q == SLOT_LAST) begin
						if (tbl_q) out_used_q <= out_used_q + 1'b1;
						else in_used_q <= in_used_q + 1'b1;
						out_q.status         <= ST_OK;
						out_q.which_table    <= tbl_q;
						out_q.entry_position <= 8'(pos_q);
						out_q.trunk_number   <= trunk_sel;
						out_q.counter_slot   <= sl_q[0];
						out_q.counter_value  <= 32'd1;
						out_q.last           <= tbl_q;
						out_v_q              <= 1'b1;
						state_q              <= S_EMIT;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				S_UPD_RD: state_q <= S_UPD_WR;
				// saturating read-modify-write of the four selected counters
				S_UPD_WR: begin
					if (k_q == 5'd0) out_q.counter_value <= cnt_wdata;
					if (k_q == 5'd3) begin
						out_q.status         <= ST_OK;
						out_q.which_table    <= tbl_q;
						out_q.entry_position <= 8'(pos_q);
						out_q.trunk_number   <= trunk_sel;
						out_q.counter_slot   <= sl_q[0];
						out_q.last           <= tbl_q;
						out_v_q              <= 1'b1;
						state_q              <= S_EMIT;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_UPD_RD;
					end
				end
				S_RD_KEY: state_q <= S_RD_CNT;
				S_RD_CNT: begin
					if (k_q == 5'd0) key_q <= key_rdata;
					state_q <= S_RD_DAT;
				end
				S_RD_DAT: begin
					out_q.status         <= ST_OK;
					out_q.which_table    <= tbl_q;
					out_q.entry_position <= 8'(pos_q);
					out_q.trunk_number   <= key_q;
					out_q.counter_slot   <= k_q;
					out_q.counter_value  <= cnt_rdata;
					out_q.last           <= (k_q == SLOT_LAST);
					out_v_q              <= 1'b1;
					state_q              <= S_EMIT;
				end
				// hold the result until its transfer, then pick the next step
				S_EMIT: begin
					if (res.ready) begin
						out_v_q <= 1'b0;
						if (out_q.last) begin
							state_q <= S_IDLE;
						end else if (cmd_q == CMD_READ) begin
							k_q     <= k_q + 5'd1;
							state_q <= S_RD_CNT;
						end else begin
							tbl_q   <= 1'b1;
							idx_q   <= '0;
							cmp_v_q <= 1'b0;
							state_q <= S_SRCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/tth_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- tb/sv/tb_trunk_traffic_histogram_table_core.sv -----
// testbench for the trunk traffic histogram table: random and directed call records,
// reads and clears, checked transfer by transfer against an in-bench table model
// depends on tth_pkg, tth_if and the core rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_trunk_traffic_histogram_table_core;
	import tth_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	tth_rec_if rec_ch();
	tth_res_if res_ch();

	trunk_traffic_histogram_table_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec_ch.sink),
		.res(res_ch.source)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// table model state, per table: keys, counters and fill count
	logic [13:0] trunk_keys [2][ENTRIES];
	logic [31:0] slot_counts [2][ENTRIES][SLOTS];
	int          fill_count [2];

	rec_t record_queue [$];
	res_t expected_results [$];
	int   mismatches;
	bit   stimulus_done;
	bit   hold_sender;
	int   quiet_cycles;
	// transfers seen at the last rising edge
	bit   rec_accepted;
	bit   res_accepted;

	// digit decode as the block does it: stop at the first nibble above nine
	function automatic int decode_digits(input logic [15:0] code, input int digits);
		int v;
		v = 0;
		for (int k = digits - 1; k >= 0; k--) begin
			if (code[4*k +: 4] > 4'd9) break;
			v = v * 10 + code[4*k +: 4];
		end
		return v;
	endfunction

	function automatic res_t make_result(input logic [1:0] st, input logic tbl,
		input logic [7:0] pos, input logic [13:0] trunk, input logic [4:0] slot,
		input logic [31:0] val, input logic lst);
		res_t r;
		r.status = st;
		r.which_table = tbl;
		r.entry_position = pos;
		r.trunk_number = trunk;
		r.counter_slot = slot;
		r.counter_value = val;
		r.last = lst;
		return r;
	endfunction

	// one table's part of a count record
	function automatic void tally_table(input int tbl, input int trunk,
		input int sl [4], input logic lst);
		int i;
		i = 0;
		while (i < fill_count[tbl] && trunk_keys[tbl][i] != trunk) i++;
		if (i >= fill_count[tbl]) begin
			if (fill_count[tbl] >= ENTRIES) begin
				expected_results.push_back(make_result(ST_FULL, tbl[0], 8'd0,
					14'(trunk), 5'd0, 32'd0, lst));
				return;
			end
			trunk_keys[tbl][i] = 14'(trunk);
			for (int k = 0; k < SLOTS; k++) slot_counts[tbl][i][k] = 32'd0;
			fill_count[tbl]++;
		end
		// saturating increment; new entries go from zero to one
		for (int k = 0; k < 4; k++)
			if (slot_counts[tbl][i][sl[k]] != 32'hffff_ffff)
				slot_counts[tbl][i][sl[k]]++;
		expected_results.push_back(make_result(ST_OK, tbl[0], 8'(i), 14'(trunk),
			5'(sl[0]), slot_counts[tbl][i][sl[0]], lst));
	endfunction

	// expected transfers caused by one accepted record
	function automatic void predict_record(input rec_t r);
		int ldc, cce, tmv, tbl, idx;
		int sl [4];
		case (r.cmd)
			CMD_COUNT: begin
				ldc = decode_digits({8'd0, r.ldc_code}, 2);
				cce = decode_digits({8'd0, r.cce_code}, 2);
				tmv = decode_digits({8'd0, r.tm_code}, 2);
				if ((r.hid_code != HID_CODE0 && r.hid_code != HID_CODE1) ||
					ldc > 3 || cce > 4 || tmv > 8) begin
					expected_results.push_back(make_result(ST_BAD_CAT, 1'b0, 8'd0,
						14'd0, 5'd0, 32'd0, 1'b1));
				end else begin
					sl[0] = (r.hid_code == HID_CODE1) ? 1 : 0;
					sl[1] = LDC_BASE + ldc;
					sl[2] = CCE_BASE + cce;
					sl[3] = TM_BASE + tmv;
					tally_table(0, decode_digits(r.in_trunk_code, 4), sl, 1'b0);
					tally_table(1, decode_digits(r.out_trunk_code, 4), sl, 1'b1);
				end
			end
			CMD_READ: begin
				tbl = r.table_select;
				idx = r.read_index;
				if (idx >= fill_count[tbl]) begin
					expected_results.push_back(make_result(ST_NO_ENTRY, r.table_select,
						r.read_index, 14'd0, 5'd0, 32'd0, 1'b1));
				end else begin
					for (int k = 0; k < SLOTS; k++)
						expected_results.push_back(make_result(ST_OK, r.table_select,
							r.read_index, trunk_keys[tbl][idx], 5'(k),
							slot_counts[tbl][idx][k], k == SLOTS - 1));
				end
			end
			CMD_CLEAR: begin
				fill_count[0] = 0;
				fill_count[1] = 0;
				expected_results.push_back(make_result(ST_OK, 1'b0, 8'd0, 14'd0, 5'd0,
					32'd0, 1'b1));
			end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] rand_bcd2(input int hi);
		int v;
		v = $urandom_range(0, hi);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// trunk codes from a small pool so that hits are common
	function automatic logic [15:0] rand_trunk(input int pool);
		int v;
		if ($urandom_range(0, 15) == 0) return 16'($urandom());
		v = $urandom_range(0, pool);
		return {4'(v / 1000), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function automatic rec_t count_rec(input logic [7:0] hid, input logic [7:0] ldc,
		input logic [7:0] cce, input logic [7:0] tmc, input logic [15:0] itg,
		input logic [15:0] otg);
		rec_t r;
		r = rec_t'($urandom());
		r.cmd = CMD_COUNT;
		r.hid_code = hid;
		r.ldc_code = ldc;
		r.cce_code = cce;
		r.tm_code = tmc;
		r.in_trunk_code = itg;
		r.out_trunk_code = otg;
		return r;
	endfunction

	function automatic rec_t read_rec(input logic tbl, input logic [7:0] idx);
		rec_t r;
		r = rec_t'({$urandom(), $urandom(), $urandom()});
		r.cmd = CMD_READ;
		r.table_select = tbl;
		r.read_index = idx;
		return r;
	endfunction

	function automatic rec_t clear_rec();
		rec_t r;
		r = rec_t'({$urandom(), $urandom(), $urandom()});
		r.cmd = CMD_CLEAR;
		return r;
	endfunction

	// well-formed record with random content
	function automatic rec_t good_count(input int pool);
		return count_rec($urandom_range(0, 1) ? HID_CODE1 : HID_CODE0, rand_bcd2(3),
			rand_bcd2(4), rand_bcd2(8), rand_trunk(pool), rand_trunk(pool));
	endfunction

	// stimulus: directed part, then random mix
	initial begin
		rec_t r;
		int pick;
		stimulus_done = 1'b0;
		hold_sender = 1'b0;
		// reads of an empty table, then extremes of the codes
		record_queue.push_back(read_rec(1'b0, 8'd0));
		record_queue.push_back(read_rec(1'b1, 8'hff));
		record_queue.push_back(count_rec(HID_CODE0, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h9999));
		record_queue.push_back(count_rec(HID_CODE1, 8'h03, 8'h04, 8'h08, 16'h9999,
			16'h0000));
		record_queue.push_back(count_rec(HID_CODE1, 8'h03, 8'h04, 8'h08, 16'h9999,
			16'h0000));
		// bad nibbles stop the decode: leading bad nibble gives zero
		record_queue.push_back(count_rec(HID_CODE0, 8'hf3, 8'ha9, 8'h0f, 16'hffff,
			16'h12ab));
		record_queue.push_back(count_rec(HID_CODE0, 8'h1a, 8'h00, 8'h00, 16'h1234,
			16'h5f00));
		// bad categories: unknown hid, ldc and cce one past their range, tm well above its range
		record_queue.push_back(count_rec(8'h00, 8'h00, 8'h00, 8'h00, 16'h0001, 16'h0001));
		record_queue.push_back(count_rec(8'hff, 8'h00, 8'h00, 8'h00, 16'h0001, 16'h0001));
		record_queue.push_back(count_rec(HID_CODE0, 8'h04, 8'h00, 8'h00, 16'h0001,
			16'h0001));
		record_queue.push_back(count_rec(HID_CODE0, 8'h00, 8'h05, 8'h00, 16'h0001,
			16'h0001));
		record_queue.push_back(count_rec(HID_CODE0, 8'h00, 8'h00, 8'h99, 16'h0001,
			16'h0001));
		record_queue.push_back(read_rec(1'b0, 8'd0));
		record_queue.push_back(read_rec(1'b1, 8'd1));
		record_queue.push_back(read_rec(1'b1, 8'd3));
		r = clear_rec();
		r.cmd = 2'd3;
		record_queue.push_back(r);
		record_queue.push_back(clear_rec());
		record_queue.push_back(read_rec(1'b0, 8'd0));
		// random part
		for (int n = 0; n < 190; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) r = good_count(40);
			else if (pick < 75) r = count_rec(8'($urandom()), 8'($urandom()),
				8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()));
			else if (pick < 93) r = read_rec(1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 12)));
			else r = clear_rec();
			record_queue.push_back(r);
		end
		// end on a clear and reads of the emptied table
		record_queue.push_back(clear_rec());
		record_queue.push_back(read_rec(1'b1, 8'hff));
		record_queue.push_back(read_rec(1'b1, 8'd0));
		wait (record_queue.size() == 0);
		stimulus_done = 1'b1;
	end

	// sender: one record per transfer with a random gap before each
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_ch.valid <= 1'b0;
			rec_ch.data <= '0;
			send_gap <= $urandom_range(0, 17);
		end else if (rec_ch.valid && !rec_accepted) begin
			// hold the record until it is taken
		end else if (hold_sender || record_queue.size() == 0) begin
			rec_ch.valid <= 1'b0;
		end else if (send_gap > 0) begin
			rec_ch.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else begin
			rec_ch.valid <= 1'b1;
			rec_ch.data <= record_queue.pop_front();
			// stretches without gaps now and then
			send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		end
	end

	// receiver: random stall before each result transfer
	int sink_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap <= $urandom_range(0, 17);
		end else if (res_accepted) begin
			res_ch.ready <= 1'b0;
			sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		end else if (sink_gap > 0) begin
			res_ch.ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// record monitor and result checker at the rising edge
	res_t got, want;
	always @(posedge clk) begin
		if (arst_n) begin
			rec_accepted <= rec_ch.valid && rec_ch.ready;
			res_accepted <= res_ch.valid && res_ch.ready;
			if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (rec_ch.valid && rec_ch.ready) begin
				predict_record(rec_ch.data);
			end
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, got %p", want, got);
					end
				end
			end
		end
	end

	// reset, pressure pause, drain and final verdict
	initial begin
		arst_n = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// once fewer than 150 records are left in the queue, let the block drain completely once
		wait (record_queue.size() < 150);
		hold_sender = 1'b1;
		wait (expected_results.size() == 0);
		@(negedge clk);
		hold_sender = 1'b0;
		wait (stimulus_done && expected_results.size() == 0 && !rec_ch.valid);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog on cycles without any transfer
	initial begin
		wait (arst_n);
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
